[hdl/assert_macros.svh]
// Assertion macros shared by the queue RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/mpq_pkg.sv]
// Shared types and constants for the priority job queue.
// No dependencies; imported by mpq_cell and the top level.
`timescale 1ns / 1ps

package mpq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int HANDLE_W    = 16;
    localparam int PRIO_W      = 8;
    localparam int COUNT_OUT_W = 5;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [PRIO_W-1:0]   prio;
    } entry_t;

    // Command broadcast to every cell
    typedef struct packed {
        logic   add;
        logic   pop;
        logic   clr;
        entry_t new_ent;
    } cell_ctrl_t;

    // What a cell shows its neighbors
    typedef struct packed {
        logic   valid;
        logic   stay;
        entry_t ent;
    } cell_link_t;

endpackage

[hdl/mpq_cell.sv]
// One slot of the sorted queue chain.
// Depends on mpq_pkg (entry, control and link types).
`timescale 1ns / 1ps

module mpq_cell
    import mpq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  cell_link_t left_link,   // toward the head
    input  cell_link_t right_link,  // toward the tail
    output cell_link_t own_link
);

    logic   valid_reg, valid_next;
    entry_t ent_reg, ent_next;
    logic   stay;

    // Entry stays put on add when it is served no later than the new job
    assign stay = valid_reg && (ent_reg.prio >= ctrl.new_ent.prio);

    assign own_link.valid = valid_reg;
    assign own_link.stay  = stay;
    assign own_link.ent   = ent_reg;

    // Next slot contents
    always_comb
    begin
        valid_next = valid_reg;
        ent_next   = ent_reg;
        if (ctrl.clr)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.pop)
        begin
            valid_next = right_link.valid;
            ent_next   = right_link.ent;
        end
        else if (ctrl.add && !stay)
        begin
            if (left_link.stay)
            begin
                valid_next = 1'b1;
                ent_next   = ctrl.new_ent;
            end
            else
            begin
                valid_next = left_link.valid;
                ent_next   = left_link.ent;
            end
        end
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

endmodule

[hdl/max_priority_job_queue_unit.sv]
// Top level of the priority job queue: a chain of sorted cells plus a result register.
// Depends on mpq_pkg, mpq_cell and assert_macros.svh.
//
//  channel | direction | tdata (low bit up)                        | tuser
//  s       | in        | job_handle[15:0] job_priority[23:16]      | op[1:0]
//  m       | out       | popped_handle[15:0] popped_priority[23:16] | add_accepted[0]
//          |           | entry_count[28:24] is_empty[29] is_full[30]| pop_valid[1]
//
// One request per cycle while s_tready is high; its result appears in the cycle after acceptance.
// The cells sit in priority order (stable among equal priorities), so pop reads the head cell.
// Reset clears every cell valid bit and the count at once; no clearing pass.
// s_tready drops only while a result waits in the output register and m_tready is low.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module max_priority_job_queue_unit
    import mpq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // job_handle[15:0], job_priority[23:16]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // popped_handle[15:0], popped_priority[23:16],
                                   // entry_count[28:24], is_empty[29], is_full[30], zero[31]
    output logic [1:0]  m_tuser    // add_accepted[0], pop_valid[1]
);

    logic             accept;
    op_t              op;
    logic             full, empty;
    logic [CNT_W-1:0] count_reg, count_next;
    cell_ctrl_t       ctrl;
    cell_link_t       links [QUEUE_DEPTH];
    cell_link_t       left_in [QUEUE_DEPTH];
    cell_link_t       right_in [QUEUE_DEPTH];

    logic                   m_valid_reg;
    logic                   res_add_reg, res_pop_reg;
    entry_t                 res_ent_reg;
    logic [COUNT_OUT_W-1:0] res_count_reg;
    logic                   res_empty_reg, res_full_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign op       = op_t'(s_tuser);
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);

    // Decode the accepted request into a chain command
    always_comb
    begin
        ctrl.add            = 1'b0;
        ctrl.pop            = 1'b0;
        ctrl.clr            = 1'b0;
        ctrl.new_ent.handle = s_tdata[15:0];
        ctrl.new_ent.prio   = s_tdata[23:16];
        count_next          = count_reg;
        if (accept)
        begin
            case (op)
                OP_ADD:
                begin
                    ctrl.add = !full;
                    if (!full)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_POP:
                begin
                    ctrl.pop = !empty;
                    if (!empty)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                OP_CLEAR:
                begin
                    ctrl.clr   = 1'b1;
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    // Cell chain, head at index 0
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                assign left_in[gi] = '{valid: 1'b1, stay: 1'b1, ent: '0};
            end
            else
            begin : g_mid
                assign left_in[gi] = links[gi-1];
            end
            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                assign right_in[gi] = '{valid: 1'b0, stay: 1'b0, ent: '0};
            end
            else
            begin : g_body
                assign right_in[gi] = links[gi+1];
            end

            mpq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .left_link  (left_in[gi]),
                .right_link (right_in[gi]),
                .own_link   (links[gi])
            );
        end
    endgenerate

    // Occupancy count and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_add_reg   <= ctrl.add;
            res_pop_reg   <= ctrl.pop;
            res_ent_reg   <= ctrl.pop ? links[0].ent : '0;
            res_count_reg <= COUNT_OUT_W'(count_next);
            res_empty_reg <= (count_next == '0);
            res_full_reg  <= (count_next == CNT_W'(QUEUE_DEPTH));
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, res_full_reg, res_empty_reg, res_count_reg,
                       res_ent_reg.prio, res_ent_reg.handle};
    assign m_tuser  = {res_pop_reg, res_add_reg};

    // Checks
    `ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(QUEUE_DEPTH), "count above depth")
    `ASSERT_ALWAYS(a_head_valid, links[0].valid == (count_reg != '0), "head valid vs count")
    `ASSERT_ALWAYS(a_head_order,
        !links[1].valid || (links[0].valid && links[0].ent.prio >= links[1].ent.prio),
        "head cells out of order")
    `ASSERT_NEXT(a_pop_count, ctrl.pop,
        count_reg == CNT_W'($past(count_reg) - CNT_W'(1)), "pop did not decrement count")

endmodule
